>>> hdl/sf2ge_pkg.sv
// Shared types, constants and helper functions of the SF2 generator encoder.
`timescale 1ns / 1ps

package sf2ge_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned LOG_FB        = 24;
  localparam int unsigned LATENCY       = 29;
  localparam logic signed [63:0] CB_K   = 64'sd1010089052;
  localparam logic signed [63:0] HZ_OFF = 64'sd61029946558;

  typedef enum logic [4:0] {
    OP_KEY_RANGE     = 5'd0,
    OP_VEL_RANGE     = 5'd1,
    OP_START_OFS     = 5'd2,
    OP_ATTEN         = 5'd3,
    OP_PAN           = 5'd4,
    OP_FILTER_FC     = 5'd5,
    OP_FILTER_Q      = 5'd6,
    OP_VOL_DELAY     = 5'd7,
    OP_VOL_ATTACK    = 5'd8,
    OP_VOL_HOLD      = 5'd9,
    OP_VOL_DECAY     = 5'd10,
    OP_VOL_SUSTAIN   = 5'd11,
    OP_VOL_RELEASE   = 5'd12,
    OP_MOD_DELAY     = 5'd13,
    OP_MOD_ATTACK    = 5'd14,
    OP_MOD_HOLD      = 5'd15,
    OP_MOD_DECAY     = 5'd16,
    OP_MOD_SUSTAIN   = 5'd17,
    OP_MOD_RELEASE   = 5'd18,
    OP_MOD_TO_PITCH  = 5'd19,
    OP_MOD_TO_FC     = 5'd20,
    OP_SCALE_TUNE    = 5'd21,
    OP_COARSE_TUNE   = 5'd22,
    OP_FINE_TUNE     = 5'd23,
    OP_EXCL_CLASS    = 5'd24,
    OP_ROOT_KEY      = 5'd25,
    OP_SAMPLE_MODES  = 5'd26,
    OP_SAMPLE_ID     = 5'd27
  } sf2ge_op_e;

  typedef struct packed {
    logic [4:0]         op;
    logic signed [31:0] value;
    logic signed [15:0] high_value;
    logic signed [7:0]  sample_ref;
  } sf2ge_in_t;

  typedef struct packed {
    logic [15:0]        gen_opcode;
    logic signed [15:0] amount;
    logic               last;
  } sf2ge_res_t;

  // Side information that travels with an item through the log pipeline.
  typedef struct packed {
    sf2ge_op_e          op;
    logic               emit;
    logic signed [15:0] amt;
    logic [4:0]         n;
    logic               tc_small;
    logic               cb_big;
    logic               vpos;
  } sf2ge_tag_t;

  function automatic logic [15:0] gen_of_op(input sf2ge_op_e op);
    logic [15:0] g;
    case (op)
      OP_KEY_RANGE:    g = 16'd43;
      OP_VEL_RANGE:    g = 16'd44;
      OP_START_OFS:    g = 16'd0;
      OP_ATTEN:        g = 16'd48;
      OP_PAN:          g = 16'd17;
      OP_FILTER_FC:    g = 16'd8;
      OP_FILTER_Q:     g = 16'd9;
      OP_VOL_DELAY:    g = 16'd33;
      OP_VOL_ATTACK:   g = 16'd34;
      OP_VOL_HOLD:     g = 16'd35;
      OP_VOL_DECAY:    g = 16'd36;
      OP_VOL_SUSTAIN:  g = 16'd37;
      OP_VOL_RELEASE:  g = 16'd38;
      OP_MOD_DELAY:    g = 16'd25;
      OP_MOD_ATTACK:   g = 16'd26;
      OP_MOD_HOLD:     g = 16'd27;
      OP_MOD_DECAY:    g = 16'd28;
      OP_MOD_SUSTAIN:  g = 16'd29;
      OP_MOD_RELEASE:  g = 16'd30;
      OP_MOD_TO_PITCH: g = 16'd7;
      OP_MOD_TO_FC:    g = 16'd11;
      OP_SCALE_TUNE:   g = 16'd56;
      OP_COARSE_TUNE:  g = 16'd51;
      OP_FINE_TUNE:    g = 16'd52;
      OP_EXCL_CLASS:   g = 16'd57;
      OP_ROOT_KEY:     g = 16'd58;
      OP_SAMPLE_MODES: g = 16'd54;
      OP_SAMPLE_ID:    g = 16'd53;
      default:         g = 16'd0;
    endcase
    return g;
  endfunction

  // Shift right by sh with rounding half away from zero.
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] p,
                                                 input int unsigned sh);
    logic signed [63:0] half;
    logic signed [63:0] mag;
    half = 64'sd1 <<< (sh - 1);
    if (!p[63]) begin
      return (p + half) >>> sh;
    end
    mag = -p;
    return -((mag + half) >>> sh);
  endfunction

  function automatic logic signed [15:0] clamp16(input logic signed [63:0] p,
                                                 input int lo, input int hi);
    logic signed [15:0] r;
    if (p < 64'(lo)) begin
      r = 16'(lo);
    end else if (p > 64'(hi)) begin
      r = 16'(hi);
    end else begin
      r = p[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [63:0] p);
    return clamp16(p, -32768, 32767);
  endfunction

endpackage

>>> hdl/sf2ge_log2.sv
// Fraction pipeline of the base-2 logarithm: one squaring stage per result bit.
`timescale 1ns / 1ps

module sf2ge_log2 (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [31:0]          m_i,
  input  sf2ge_pkg::sf2ge_tag_t tag_i,
  output logic                 valid_o,
  output logic [sf2ge_pkg::LOG_FB-1:0] frac_o,
  output sf2ge_pkg::sf2ge_tag_t tag_o
);

  localparam int unsigned Stages = sf2ge_pkg::LOG_FB;

  logic                  vld_q  [Stages];
  logic [31:0]           m_q    [Stages];
  logic [Stages-1:0]     frac_q [Stages];
  sf2ge_pkg::sf2ge_tag_t tag_q  [Stages];

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    logic                  vld_in;
    logic [31:0]           m_in;
    logic [Stages-1:0]     frac_in;
    sf2ge_pkg::sf2ge_tag_t tag_in;
    logic [63:0]           prod;
    logic [32:0]           sq;
    logic [31:0]           m_d;
    logic [Stages-1:0]     frac_d;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign m_in    = m_i;
      assign frac_in = '0;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign m_in    = m_q[k-1];
      assign frac_in = frac_q[k-1];
      assign tag_in  = tag_q[k-1];
    end

    // The square of a Q1.31 mantissa reaches 2.0 exactly when this bit is one.
    always_comb begin
      prod   = 64'(m_in) * 64'(m_in);
      sq     = prod[63:31];
      m_d    = sq[32] ? sq[32:1] : sq[31:0];
      frac_d = {frac_in[Stages-2:0], sq[32]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      m_q[k]    <= m_d;
      frac_q[k] <= frac_d;
      tag_q[k]  <= tag_in;
    end
  end

  assign valid_o = vld_q[Stages-1];
  assign frac_o  = frac_q[Stages-1];
  assign tag_o   = tag_q[Stages-1];

endmodule

>>> hdl/sf2_zone_generator_encoder.sv
// Top level of the SF2 zone generator encoder.
// Each start transfer yields one result on done_o, or none if the item is dropped.
// Throughput: one item per cycle; busy_o stays low since every stage advances each cycle.
// The pipeline is three front stages, 24 squaring stages of the log unit, two back stages.
// Reset clears every valid bit at once; no strobe follows an item cut off by reset.
// The receiver cannot stall, so each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module sf2_zone_generator_encoder #(
  parameter int unsigned FRAC_BITS = sf2ge_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  sf2ge_pkg::sf2ge_in_t  in_i,
  output logic                  done_o,
  output sf2ge_pkg::sf2ge_res_t res_o
);

  localparam logic signed [32:0] One      = 33'sd1 <<< FRAC_BITS;
  localparam logic signed [47:0] TcLimit  = 48'sd1 <<< FRAC_BITS;
  localparam logic signed [47:0] CbLimit  = 48'sd9999 <<< FRAC_BITS;

  // Stage 1: input register.
  logic               vld1_q;
  sf2ge_pkg::sf2ge_op_e op1_q;
  logic signed [31:0] v1_q;
  logic signed [15:0] hi1_q;
  logic signed [7:0]  ref1_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q  <= sf2ge_pkg::sf2ge_op_e'(in_i.op);
    v1_q   <= in_i.value;
    hi1_q  <= in_i.high_value;
    ref1_q <= in_i.sample_ref;
  end

  // Stage 1 logic: leading one, constant products, default checks.
  logic [4:0]         n1;
  logic signed [47:0] v48;
  logic signed [47:0] p10_d, p500_d, p1000_d;
  logic signed [32:0] fine_d;
  logic               emit_d, tcs_d, cbb_d, vpos_d;

  always_comb begin
    n1 = '0;
    for (int i = 0; i < 32; i++) begin
      if (v1_q[i]) begin
        n1 = 5'(i);
      end
    end
    v48     = 48'(v1_q);
    p10_d   = v48 * 48'sd10;
    p500_d  = v48 * 48'sd500;
    p1000_d = (48'(One) - v48) * 48'sd1000;
    fine_d  = 33'(v1_q) - 33'(ref1_q);
    tcs_d   = (v48 * 48'sd2000) <= TcLimit;
    cbb_d   = (v48 * 48'sd10000) >= CbLimit;
    vpos_d  = (v1_q > 32'sd0);
    case (op1_q)
      sf2ge_pkg::OP_KEY_RANGE,
      sf2ge_pkg::OP_SAMPLE_MODES,
      sf2ge_pkg::OP_SAMPLE_ID:    emit_d = 1'b1;
      sf2ge_pkg::OP_VEL_RANGE:    emit_d = (v1_q != 32'sd0) || (hi1_q != 16'sd127);
      sf2ge_pkg::OP_START_OFS,
      sf2ge_pkg::OP_ATTEN,
      sf2ge_pkg::OP_PAN,
      sf2ge_pkg::OP_FILTER_Q,
      sf2ge_pkg::OP_MOD_TO_PITCH,
      sf2ge_pkg::OP_MOD_TO_FC,
      sf2ge_pkg::OP_COARSE_TUNE,
      sf2ge_pkg::OP_EXCL_CLASS:   emit_d = (v1_q != 32'sd0);
      sf2ge_pkg::OP_FILTER_FC,
      sf2ge_pkg::OP_VOL_DELAY,
      sf2ge_pkg::OP_VOL_ATTACK,
      sf2ge_pkg::OP_VOL_HOLD,
      sf2ge_pkg::OP_VOL_DECAY,
      sf2ge_pkg::OP_VOL_RELEASE,
      sf2ge_pkg::OP_MOD_DELAY,
      sf2ge_pkg::OP_MOD_ATTACK,
      sf2ge_pkg::OP_MOD_HOLD,
      sf2ge_pkg::OP_MOD_DECAY,
      sf2ge_pkg::OP_MOD_RELEASE:  emit_d = vpos_d;
      sf2ge_pkg::OP_VOL_SUSTAIN,
      sf2ge_pkg::OP_MOD_SUSTAIN:  emit_d = (33'(v1_q) < One);
      sf2ge_pkg::OP_SCALE_TUNE:   emit_d = (v1_q != 32'sd100);
      sf2ge_pkg::OP_FINE_TUNE:    emit_d = (fine_d != 33'sd0);
      sf2ge_pkg::OP_ROOT_KEY:     emit_d = (v1_q != 32'(ref1_q));
      default:                    emit_d = 1'b0;
    endcase
  end

  // Stage 2 register.
  logic               vld2_q;
  sf2ge_pkg::sf2ge_op_e op2_q;
  logic signed [31:0] v2_q;
  logic signed [15:0] hi2_q;
  logic [4:0]         n2_q;
  logic signed [47:0] p10_q, p500_q, p1000_q;
  logic signed [32:0] fine_q;
  logic               emit2_q, tcs2_q, cbb2_q, vpos2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op2_q   <= op1_q;
    v2_q    <= v1_q;
    hi2_q   <= hi1_q;
    n2_q    <= n1;
    p10_q   <= p10_d;
    p500_q  <= p500_d;
    p1000_q <= p1000_d;
    fine_q  <= fine_d;
    emit2_q <= emit_d;
    tcs2_q  <= tcs_d;
    cbb2_q  <= cbb_d;
    vpos2_q <= vpos_d;
  end

  // Stage 2 logic: normalize the mantissa and finish the direct amounts.
  logic [31:0]           m2;
  logic [6:0]            lo_c, hi_c;
  sf2ge_pkg::sf2ge_tag_t tag2;

  always_comb begin
    m2 = v2_q << (5'd31 - n2_q);
    if (v2_q < 32'sd0) begin
      lo_c = 7'd0;
    end else if (v2_q > 32'sd127) begin
      lo_c = 7'd127;
    end else begin
      lo_c = v2_q[6:0];
    end
    if (hi2_q < 16'sd0) begin
      hi_c = 7'd0;
    end else if (hi2_q > 16'sd127) begin
      hi_c = 7'd127;
    end else begin
      hi_c = hi2_q[6:0];
    end
    tag2.op       = op2_q;
    tag2.emit     = emit2_q;
    tag2.n        = n2_q;
    tag2.tc_small = tcs2_q;
    tag2.cb_big   = cbb2_q;
    tag2.vpos     = vpos2_q;
    case (op2_q)
      sf2ge_pkg::OP_KEY_RANGE,
      sf2ge_pkg::OP_VEL_RANGE:    tag2.amt = {1'b0, hi_c, 1'b0, lo_c};
      sf2ge_pkg::OP_ATTEN,
      sf2ge_pkg::OP_FILTER_Q:
        tag2.amt = sf2ge_pkg::sat16(sf2ge_pkg::rnd_shr(64'(p10_q), FRAC_BITS));
      sf2ge_pkg::OP_PAN:
        tag2.amt = sf2ge_pkg::sat16(sf2ge_pkg::rnd_shr(64'(p500_q), FRAC_BITS));
      sf2ge_pkg::OP_MOD_SUSTAIN:
        tag2.amt = sf2ge_pkg::sat16(sf2ge_pkg::rnd_shr(64'(p1000_q), FRAC_BITS));
      sf2ge_pkg::OP_MOD_TO_PITCH,
      sf2ge_pkg::OP_MOD_TO_FC:
        tag2.amt = sf2ge_pkg::sat16(sf2ge_pkg::rnd_shr(64'(v2_q), FRAC_BITS));
      sf2ge_pkg::OP_FINE_TUNE:    tag2.amt = sf2ge_pkg::sat16(64'(fine_q));
      sf2ge_pkg::OP_SAMPLE_MODES:
        tag2.amt = v2_q[1] ? 16'sd3 : (v2_q[0] ? 16'sd1 : 16'sd0);
      default:                    tag2.amt = sf2ge_pkg::sat16(64'(v2_q));
    endcase
  end

  // Stage 3 register, feeding the log unit.
  logic                  vld3_q;
  logic [31:0]           m3_q;
  sf2ge_pkg::sf2ge_tag_t tag3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
    end else begin
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m3_q   <= m2;
    tag3_q <= tag2;
  end

  logic                          vldl;
  logic [sf2ge_pkg::LOG_FB-1:0]  fracl;
  sf2ge_pkg::sf2ge_tag_t         tagl;

  sf2ge_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld3_q),
    .m_i     (m3_q),
    .tag_i   (tag3_q),
    .valid_o (vldl),
    .frac_o  (fracl),
    .tag_o   (tagl)
  );

  // Log value in Q.24 and the three scaled products.
  logic signed [31:0] l_s;
  logic signed [31:0] nfb;
  logic signed [63:0] tcp_d, cbp_d, hzp_d;

  always_comb begin
    nfb   = 32'(tagl.n) - 32'(FRAC_BITS);
    l_s   = (nfb <<< sf2ge_pkg::LOG_FB) + 32'(fracl);
    tcp_d = 64'(l_s) * 64'sd1200;
    cbp_d = 64'(-l_s) * sf2ge_pkg::CB_K;
    hzp_d = tcp_d - sf2ge_pkg::HZ_OFF;
  end

  logic                  vlda_q;
  sf2ge_pkg::sf2ge_tag_t taga_q;
  logic signed [63:0]    tcp_q, cbp_q, hzp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlda_q <= 1'b0;
    end else begin
      vlda_q <= vldl;
    end
  end

  always_ff @(posedge clk_i) begin
    taga_q <= tagl;
    tcp_q  <= tcp_d;
    cbp_q  <= cbp_d;
    hzp_q  <= hzp_d;
  end

  // Final rounding, clamping and selection.
  logic                  done_d;
  sf2ge_pkg::sf2ge_res_t res_d;
  logic signed [15:0]    tc_amt, cb_amt, hz_amt;

  always_comb begin
    tc_amt = taga_q.tc_small ? -16'sd12000 :
             sf2ge_pkg::clamp16(sf2ge_pkg::rnd_shr(tcp_q, sf2ge_pkg::LOG_FB), -12000, 8000);
    if (taga_q.cb_big) begin
      cb_amt = 16'sd0;
    end else if (!taga_q.vpos) begin
      cb_amt = 16'sd1440;
    end else begin
      cb_amt = sf2ge_pkg::clamp16(sf2ge_pkg::rnd_shr(cbp_q, 2 * sf2ge_pkg::LOG_FB), 0, 1440);
    end
    hz_amt = sf2ge_pkg::clamp16(sf2ge_pkg::rnd_shr(hzp_q, sf2ge_pkg::LOG_FB), 1500, 13500);
    done_d           = vlda_q && taga_q.emit;
    res_d.gen_opcode = sf2ge_pkg::gen_of_op(taga_q.op);
    res_d.last       = (taga_q.op == sf2ge_pkg::OP_SAMPLE_ID);
    case (taga_q.op)
      sf2ge_pkg::OP_VOL_DELAY,
      sf2ge_pkg::OP_VOL_ATTACK,
      sf2ge_pkg::OP_VOL_HOLD,
      sf2ge_pkg::OP_VOL_DECAY,
      sf2ge_pkg::OP_VOL_RELEASE,
      sf2ge_pkg::OP_MOD_DELAY,
      sf2ge_pkg::OP_MOD_ATTACK,
      sf2ge_pkg::OP_MOD_HOLD,
      sf2ge_pkg::OP_MOD_DECAY,
      sf2ge_pkg::OP_MOD_RELEASE:  res_d.amount = tc_amt;
      sf2ge_pkg::OP_VOL_SUSTAIN:  res_d.amount = cb_amt;
      sf2ge_pkg::OP_FILTER_FC:    res_d.amount = hz_amt;
      default:                    res_d.amount = taga_q.amt;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_o <= res_d;
  end

endmodule

>>> hdl/sf2ge_checker.sv
// Port-level checker of the SF2 generator encoder and its bind statement.
`timescale 1ns / 1ps

module sf2ge_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start_i,
  input logic                  busy_o,
  input sf2ge_pkg::sf2ge_in_t  in_i,
  input logic                  done_o,
  input sf2ge_pkg::sf2ge_res_t res_o
);

  localparam int unsigned Lat = sf2ge_pkg::LATENCY;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy_o asserted");

  a_id_emitted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && in_i.op == sf2ge_pkg::OP_SAMPLE_ID |-> ##29 done_o && res_o.last)
    else $error("sample id transfer produced no last record");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Lat))
    else $error("result without a matching start transfer");

  a_last_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.last |-> $past(in_i.op, Lat) == sf2ge_pkg::OP_SAMPLE_ID &&
                             res_o.gen_opcode == 16'd53)
    else $error("last flag on a record that is not the sample id");

endmodule

bind sf2_zone_generator_encoder sf2ge_checker u_sf2ge_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .in_i    (in_i),
  .done_o  (done_o),
  .res_o   (res_o)
);
